FILE: rtl/pfr_pkg.sv
`default_nettype none
package pfr_pkg;

    // palette geometry
    localparam int CANDIDATE_COUNT = 16;
    localparam int PALETTE_SIZE    = 256;
    localparam int IDX_W           = 8;
    localparam int GUN_W           = 8;
    localparam int RGB_W           = 3 * GUN_W;
    localparam int DIST_W          = 18;

    // candidate set is clamped to the whole palette
    localparam int CAND_NUM   = (CANDIDATE_COUNT > PALETTE_SIZE) ? PALETTE_SIZE
                                                                 : CANDIDATE_COUNT;
    localparam int CAND_START = PALETTE_SIZE - CAND_NUM;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLOR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRACTION = 8'd1;

    // func codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // palette write broadcast to the ram and the candidate cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [GUN_W-1:0] r;
        logic [GUN_W-1:0] g;
        logic [GUN_W-1:0] b;
    } pfr_wr_t;

    // data handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  qidx;
        logic [GUN_W-1:0]  r;
        logic [GUN_W-1:0]  g;
        logic [GUN_W-1:0]  b;
        logic [DIST_W-1:0] sqdist;
        logic [IDX_W-1:0]  best;
    } pfr_link_t;

endpackage
`default_nettype wire

FILE: rtl/palette_fade_remap_top.sv
`default_nettype none
// palette write: one beat per cycle while no query is in flight, no result
// query of entry 0 or of a candidate entry: bypass state, the result is the queried index
// other queries: palette reads of the target and the queried entry, fade, then a pass
// through the chain of candidate cells (16), result registered once the tail is valid
// one query in flight: the next beat is taken once the result is registered, which backpressure delays
// synchronous active-low reset clears control and both config registers; palette is not cleared
module palette_fade_remap_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [pfr_pkg::IDX_W-1:0]     s_entry_index,
    input  wire logic [pfr_pkg::GUN_W-1:0]     s_red,
    input  wire logic [pfr_pkg::GUN_W-1:0]     s_green,
    input  wire logic [pfr_pkg::GUN_W-1:0]     s_blue,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pfr_pkg::IDX_W-1:0]     m_queried_index,
    output logic      [pfr_pkg::IDX_W-1:0]     m_fade_index
);

    pfr_pkg::pfr_wr_t          wr;
    pfr_pkg::pfr_link_t        link [pfr_pkg::CAND_NUM+1];
    logic [pfr_pkg::IDX_W-1:0] ram_raddr;
    logic [pfr_pkg::RGB_W-1:0] ram_rdata;

    // palette write beat goes to the ram and the candidate cells
    always_comb begin
        wr.en  = s_valid && s_ready && (s_func == pfr_pkg::FUNC_WRITE);
        wr.idx = s_entry_index;
        wr.r   = s_red;
        wr.g   = s_green;
        wr.b   = s_blue;
    end

    pfr_ram #(
        .WIDTH(pfr_pkg::RGB_W),
        .DEPTH(pfr_pkg::PALETTE_SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.idx[$clog2(pfr_pkg::PALETTE_SIZE)-1:0]),
        .wdata ({wr.r, wr.g, wr.b}),
        .raddr (ram_raddr[$clog2(pfr_pkg::PALETTE_SIZE)-1:0]),
        .rdata (ram_rdata)
    );

    pfr_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_entry_index   (s_entry_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .head            (link[0]),
        .tail            (link[pfr_pkg::CAND_NUM]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_queried_index (m_queried_index),
        .m_fade_index    (m_fade_index)
    );

    // one cell per candidate entry, lowest index first
    for (genvar i = 0; i < pfr_pkg::CAND_NUM; i++) begin : g_cell
        pfr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cand_idx (pfr_pkg::IDX_W'(pfr_pkg::CAND_START + i)),
            .wr       (wr),
            .up       (link[i]),
            .down     (link[i+1])
        );
    end

endmodule
`default_nettype wire

FILE: rtl/pfr_ram.sv
`default_nettype none
module pfr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/pfr_cell.sv
`default_nettype none
module pfr_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [pfr_pkg::IDX_W-1:0] cand_idx,
    input  wire pfr_pkg::pfr_wr_t         wr,
    input  wire pfr_pkg::pfr_link_t       up,
    output pfr_pkg::pfr_link_t            down
);

    logic [pfr_pkg::GUN_W-1:0] cand_r_reg, cand_g_reg, cand_b_reg;
    pfr_pkg::pfr_link_t        down_reg, down_next;

    logic signed [pfr_pkg::GUN_W:0]     dr, dg, db;
    logic signed [2*pfr_pkg::GUN_W+1:0] sr, sg, sb;
    logic [pfr_pkg::DIST_W-1:0]         sqdist;

    // shadow copy of this candidate's colour
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.idx == cand_idx)) begin
            cand_r_reg <= wr.r;
            cand_g_reg <= wr.g;
            cand_b_reg <= wr.b;
        end
    end

    // squared distance of the ideal colour to this candidate
    always_comb begin
        dr     = $signed({1'b0, cand_r_reg}) - $signed({1'b0, up.r});
        dg     = $signed({1'b0, cand_g_reg}) - $signed({1'b0, up.g});
        db     = $signed({1'b0, cand_b_reg}) - $signed({1'b0, up.b});
        sr     = (2*pfr_pkg::GUN_W+2)'(dr) * (2*pfr_pkg::GUN_W+2)'(dr);
        sg     = (2*pfr_pkg::GUN_W+2)'(dg) * (2*pfr_pkg::GUN_W+2)'(dg);
        sb     = (2*pfr_pkg::GUN_W+2)'(db) * (2*pfr_pkg::GUN_W+2)'(db);
        sqdist = pfr_pkg::DIST_W'($unsigned(sr))
               + pfr_pkg::DIST_W'($unsigned(sg))
               + pfr_pkg::DIST_W'($unsigned(sb));
    end

    // keep the running best, lower index wins ties
    always_comb begin
        down_next = up;
        if (sqdist < up.sqdist) begin
            down_next.sqdist = sqdist;
            down_next.best   = cand_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg.valid <= 1'b0;
        end else begin
            down_reg.valid <= up.valid;
        end
        down_reg.qidx   <= down_next.qidx;
        down_reg.r      <= down_next.r;
        down_reg.g      <= down_next.g;
        down_reg.b      <= down_next.b;
        down_reg.sqdist <= down_next.sqdist;
        down_reg.best   <= down_next.best;
    end

    assign down = down_reg;

endmodule
`default_nettype wire

FILE: rtl/pfr_ctrl.sv
`default_nettype none
module pfr_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // query side of the input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [pfr_pkg::IDX_W-1:0]     s_entry_index,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    // palette read port
    output logic      [pfr_pkg::IDX_W-1:0]     ram_raddr,
    input  wire logic [pfr_pkg::RGB_W-1:0]     ram_rdata,
    // candidate chain
    output pfr_pkg::pfr_link_t                 head,
    input  wire pfr_pkg::pfr_link_t            tail,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pfr_pkg::IDX_W-1:0]     m_queried_index,
    output logic      [pfr_pkg::IDX_W-1:0]     m_fade_index
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_TGT, ST_RD_ENT, ST_FADE, ST_INJECT, ST_RUN, ST_BYPASS
    } state_t;

    localparam int G = pfr_pkg::GUN_W;

    state_t                    state_reg;
    logic [pfr_pkg::IDX_W-1:0] target_reg, qidx_reg;
    logic [7:0]                fade_reg;
    logic [G-1:0]              tgt_r_reg, tgt_g_reg, tgt_b_reg;
    logic [G-1:0]              ideal_r_reg, ideal_g_reg, ideal_b_reg;
    logic                      out_valid_reg;
    logic [pfr_pkg::IDX_W-1:0] out_qidx_reg, out_ridx_reg;

    logic       accept, out_free, bypass;
    logic [6:0] half;

    // move one gun toward the target by floor(diff * half / 128)
    function automatic logic [G-1:0] fade_gun(input logic [G-1:0] orig,
                                              input logic [G-1:0] tgt,
                                              input logic [6:0]   h);
        logic signed [G:0]   d;
        logic signed [G+8:0] p;
        logic [G-1:0]        step;
        d    = $signed({1'b0, orig}) - $signed({1'b0, tgt});
        p    = (G+9)'(d) * (G+9)'($signed({1'b0, h}));
        step = G'(p >>> 7);
        return orig - step;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign half      = fade_reg[7:1];
    assign bypass    = (s_entry_index == '0)
                    || ({1'b0, s_entry_index} >= 9'(pfr_pkg::CAND_START));

    // target entry first, then the queried entry
    assign ram_raddr = (state_reg == ST_RD_TGT) ? target_reg : qidx_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            fade_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfr_pkg::CFG_TARGET_COLOR:  target_reg <= cfg_data;
                pfr_pkg::CFG_FADE_FRACTION: fade_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // query sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_func == pfr_pkg::FUNC_QUERY)) begin
                        qidx_reg  <= s_entry_index;
                        state_reg <= bypass ? ST_BYPASS : ST_RD_TGT;
                    end
                end
                ST_RD_TGT: begin
                    state_reg <= ST_RD_ENT;
                end
                ST_RD_ENT: begin
                    tgt_r_reg <= ram_rdata[3*G-1:2*G];
                    tgt_g_reg <= ram_rdata[2*G-1:G];
                    tgt_b_reg <= ram_rdata[G-1:0];
                    state_reg <= ST_FADE;
                end
                ST_FADE: begin
                    ideal_r_reg <= fade_gun(ram_rdata[3*G-1:2*G], tgt_r_reg, half);
                    ideal_g_reg <= fade_gun(ram_rdata[2*G-1:G], tgt_g_reg, half);
                    ideal_b_reg <= fade_gun(ram_rdata[G-1:0], tgt_b_reg, half);
                    state_reg   <= ST_INJECT;
                end
                ST_INJECT: begin
                    if (out_free) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (tail.valid) begin
                        out_valid_reg <= 1'b1;
                        out_qidx_reg  <= tail.qidx;
                        out_ridx_reg  <= tail.best;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_BYPASS: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_qidx_reg  <= qidx_reg;
                        out_ridx_reg  <= qidx_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ideal colour enters the chain with no best yet
    always_comb begin
        head.valid  = (state_reg == ST_INJECT) && out_free;
        head.qidx   = qidx_reg;
        head.r      = ideal_r_reg;
        head.g      = ideal_g_reg;
        head.b      = ideal_b_reg;
        head.sqdist = '1;
        head.best   = '0;
    end

    assign m_valid         = out_valid_reg;
    assign m_queried_index = out_qidx_reg;
    assign m_fade_index    = out_ridx_reg;

endmodule
`default_nettype wire

FILE: tb/palette_fade_remap_top_test.sv
`default_nettype none
module palette_fade_remap_top_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 48;

    // register indexes outside the list, the block must ignore them
    localparam logic [pfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [pfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'd255;

    typedef struct {
        logic [pfr_pkg::IDX_W-1:0] qidx;
        logic [pfr_pkg::IDX_W-1:0] remap;
    } remap_result_t;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic                          s_func          = pfr_pkg::FUNC_WRITE;
    logic [pfr_pkg::IDX_W-1:0]     s_entry_index   = '0;
    logic [pfr_pkg::GUN_W-1:0]     s_red           = '0;
    logic [pfr_pkg::GUN_W-1:0]     s_green         = '0;
    logic [pfr_pkg::GUN_W-1:0]     s_blue          = '0;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
    logic [7:0]                    cfg_data        = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b1;
    logic [pfr_pkg::IDX_W-1:0]     m_queried_index;
    logic [pfr_pkg::IDX_W-1:0]     m_fade_index;

    // shadow of the palette and the registers
    logic [pfr_pkg::GUN_W-1:0] pal_r [pfr_pkg::PALETTE_SIZE];
    logic [pfr_pkg::GUN_W-1:0] pal_g [pfr_pkg::PALETTE_SIZE];
    logic [pfr_pkg::GUN_W-1:0] pal_b [pfr_pkg::PALETTE_SIZE];
    bit                        pal_written [pfr_pkg::PALETTE_SIZE];
    logic [pfr_pkg::IDX_W-1:0] known_entries [$];
    logic [7:0]                tgt_reg  = '0;
    logic [7:0]                fade_reg = '0;

    remap_result_t pending_remaps [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            idle_on        = 1'b1;
    int            stall_cnt      = 0;

    palette_fade_remap_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_entry_index   (s_entry_index),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_queried_index (m_queried_index),
        .m_fade_index    (m_fade_index)
    );

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("palette_fade_remap_top_test: FAIL");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(negedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_cnt = $urandom_range(1, 8) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        remap_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_remaps.size() == 0) begin
                $error("unexpected result beat: queried_index %0d fade_index %0d",
                       m_queried_index, m_fade_index);
                mismatch_count++;
            end else begin
                want = pending_remaps.pop_front();
                if (m_queried_index !== want.qidx) begin
                    $error("queried_index: expected %0d, actual %0d",
                           want.qidx, m_queried_index);
                    mismatch_count++;
                end
                if (m_fade_index !== want.remap) begin
                    $error("fade_index: expected %0d, actual %0d",
                           want.remap, m_fade_index);
                    mismatch_count++;
                end
            end
        end
    end

    // one gun moved toward the target, floor division by 128
    function automatic int fade_gun(input int orig, input int target, input int half);
        return orig - (((orig - target) * half) >>> 7);
    endfunction

    // entry 0, candidates map to themselves; else nearest candidate, lowest index on a tie
    function automatic logic [pfr_pkg::IDX_W-1:0] predict_remap(
        input logic [pfr_pkg::IDX_W-1:0] idx);
        int half, ir, ig, ib, dr, dg, db, sqd, best_dist, best, c;
        if (idx == 0)
            return '0;
        if (idx >= pfr_pkg::CAND_START)
            return idx;
        half = fade_reg >> 1;
        ir = fade_gun(pal_r[idx], pal_r[tgt_reg], half);
        ig = fade_gun(pal_g[idx], pal_g[tgt_reg], half);
        ib = fade_gun(pal_b[idx], pal_b[tgt_reg], half);
        best      = tgt_reg;
        best_dist = 32'h7fffffff;
        for (c = pfr_pkg::CAND_START; c < pfr_pkg::PALETTE_SIZE; c++) begin
            dr  = int'(pal_r[c]) - ir;
            dg  = int'(pal_g[c]) - ig;
            db  = int'(pal_b[c]) - ib;
            sqd = dr * dr + dg * dg + db * db;
            if (sqd < best_dist) begin
                best_dist = sqd;
                best      = c;
            end
        end
        return best[pfr_pkg::IDX_W-1:0];
    endfunction

    // drive one input beat, hold until taken, then update the shadow or queue the prediction
    task automatic send_palette_beat(input logic func,
                                     input logic [pfr_pkg::IDX_W-1:0] idx,
                                     input logic [pfr_pkg::GUN_W-1:0] r,
                                     input logic [pfr_pkg::GUN_W-1:0] g,
                                     input logic [pfr_pkg::GUN_W-1:0] b);
        int gap;
        remap_result_t want;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_entry_index <= idx;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        do @(posedge aclk); while (!s_ready);
        if (func == pfr_pkg::FUNC_WRITE) begin
            pal_r[idx] = r;
            pal_g[idx] = g;
            pal_b[idx] = b;
            if (idx != 0 && idx < pfr_pkg::CAND_START && !pal_written[idx])
                known_entries.push_back(idx);
            pal_written[idx] = 1'b1;
        end else begin
            want.qidx  = idx;
            want.remap = predict_remap(idx);
            pending_remaps.push_back(want);
        end
    endtask

    task automatic drop_input_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait for every result, then let a write still in the pipe finish
    task automatic settle_block();
        drop_input_valid();
        while (pending_remaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [pfr_pkg::CFG_IDX_W-1:0] index,
                                  input logic [7:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (index == pfr_pkg::CFG_TARGET_COLOR)
            tgt_reg = data;
        else if (index == pfr_pkg::CFG_FADE_FRACTION)
            fade_reg = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic query_entry(input logic [pfr_pkg::IDX_W-1:0] idx);
        send_palette_beat(pfr_pkg::FUNC_QUERY, idx, 8'($urandom), 8'($urandom),
                          8'($urandom));
    endtask

    function automatic logic [pfr_pkg::GUN_W-1:0] random_gun();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 8'($urandom);
        endcase
    endfunction

    // entry zero, the candidate set with duplicate colours, two plain entries
    task automatic test_palette_load();
        logic [23:0] seed [16];
        int k;
        seed = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'h808080, 24'hFFFF00, 24'h000000,
                 24'h404040, 24'hC0C0C0, 24'hFF00FF, 24'h00FFFF,
                 24'h800000, 24'h008000, 24'h000080, 24'hFFFFFF};
        send_palette_beat(pfr_pkg::FUNC_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
        for (k = 0; k < 16; k++)
            send_palette_beat(pfr_pkg::FUNC_WRITE, 8'(pfr_pkg::CAND_START + k),
                              seed[k][23:16], seed[k][15:8], seed[k][7:0]);
        send_palette_beat(pfr_pkg::FUNC_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        send_palette_beat(pfr_pkg::FUNC_WRITE, 8'(pfr_pkg::CAND_START - 1),
                          8'h00, 8'h00, 8'h00);
    endtask

    // entry zero answers zero, candidates answer themselves
    task automatic test_fixed_answers();
        query_entry(8'd0);
        query_entry(8'(pfr_pkg::CAND_START));
        query_entry(8'hFF);
    endtask

    // exact matches on duplicated candidates pick the lower index
    task automatic test_nearest_and_ties();
        query_entry(8'd1);
        query_entry(8'(pfr_pkg::CAND_START - 1));
    endtask

    // maximum fade toward white, no fade at fraction one, half fade to black
    task automatic test_fade_extremes();
        settle_block();
        write_register(pfr_pkg::CFG_TARGET_COLOR, 8'(pfr_pkg::CAND_START + 1));
        write_register(pfr_pkg::CFG_FADE_FRACTION, 8'hFF);
        query_entry(8'(pfr_pkg::CAND_START - 1));
        query_entry(8'd1);
        settle_block();
        write_register(pfr_pkg::CFG_FADE_FRACTION, 8'd1);
        query_entry(8'(pfr_pkg::CAND_START - 1));
        settle_block();
        write_register(pfr_pkg::CFG_TARGET_COLOR, 8'd0);
        write_register(pfr_pkg::CFG_FADE_FRACTION, 8'd128);
        query_entry(8'd1);
    endtask

    // writes to indexes past the list leave both registers alone
    task automatic test_unused_registers();
        settle_block();
        write_register(CFG_UNUSED_LO, 8'hFF);
        write_register(CFG_UNUSED_HI, 8'h00);
        query_entry(8'd1);
    endtask

    function automatic logic [7:0] pick_target();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 8'($urandom_range(pfr_pkg::CAND_START, pfr_pkg::PALETTE_SIZE - 1));
            default: return known_entries[$urandom_range(0, known_entries.size() - 1)];
        endcase
    endfunction

    task automatic random_item();
        int sel, src;
        logic [pfr_pkg::IDX_W-1:0] idx;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            if (sel < 12)
                idx = 8'($urandom_range(pfr_pkg::CAND_START, pfr_pkg::PALETTE_SIZE - 1));
            else
                idx = 8'($urandom);
            if (idx >= pfr_pkg::CAND_START && $urandom_range(0, 2) == 0) begin
                // copy another candidate so that ties come up
                src = $urandom_range(pfr_pkg::CAND_START, pfr_pkg::PALETTE_SIZE - 1);
                send_palette_beat(pfr_pkg::FUNC_WRITE, idx, pal_r[src], pal_g[src],
                                  pal_b[src]);
            end else begin
                send_palette_beat(pfr_pkg::FUNC_WRITE, idx, random_gun(), random_gun(),
                                  random_gun());
            end
        end else begin
            case ($urandom_range(0, 9))
                0: idx = '0;
                1: idx = 8'($urandom_range(pfr_pkg::CAND_START, pfr_pkg::PALETTE_SIZE - 1));
                default: idx = known_entries[$urandom_range(0, known_entries.size() - 1)];
            endcase
            query_entry(idx);
        end
    endtask

    // phases of mixed writes and queries, each under its own setting
    task automatic test_random_traffic();
        logic [7:0] fade_steps [7];
        int phase, n;
        logic [7:0] tgt, fade;
        fade_steps = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd254, 8'd255};
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1)
                idle_on = 1'b0;
            settle_block();
            if (phase == 0)
                tgt = '0;
            else if (phase == 1)
                tgt = 8'hFF;
            else
                tgt = pick_target();
            if (phase < 7)
                fade = fade_steps[phase];
            else
                fade = 8'($urandom);
            write_register(pfr_pkg::CFG_TARGET_COLOR, tgt);
            write_register(pfr_pkg::CFG_FADE_FRACTION, fade);
            if ($urandom_range(0, 3) == 0)
                write_register(8'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                               8'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_palette_load();
        test_fixed_answers();
        test_nearest_and_ties();
        test_fade_extremes();
        test_unused_registers();
        test_random_traffic();
        drop_input_valid();
        while (pending_remaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("palette_fade_remap_top_test: PASS");
        end else begin
            $display("palette_fade_remap_top_test: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/pfr_pkg.sv
rtl/pfr_ram.sv
rtl/pfr_cell.sv
rtl/pfr_ctrl.sv
rtl/palette_fade_remap_top.sv
tb/palette_fade_remap_top_test.sv
